// ===== rtl/sag_pkg.sv =====
package sag_pkg;

    localparam int ACCOUNT_SLOTS = 256;
    localparam int PAIR_SLOTS    = 256;

    localparam int ACC_IDX_W = (ACCOUNT_SLOTS > 1) ? $clog2(ACCOUNT_SLOTS) : 1;
    localparam int PAIR_IDX_W = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
    localparam int PAIR_CNT_W = $clog2(PAIR_SLOTS + 1);

    localparam int ACCT_W   = 32;
    localparam int ADDR_W   = 32;
    localparam int HANDLE_W = 16;
    localparam int CAP_W    = 16;
    localparam int CFG_IDX_W = 4;

    localparam int S_TDATA_W = 88;
    localparam int M_TDATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_ONE_PER_ACCOUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_ADDRESS = CFG_IDX_W'(1);

    localparam logic KIND_REGISTER   = 1'b0;
    localparam logic KIND_UNREGISTER = 1'b1;

    localparam logic [1:0] OP_CONN = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_CLR  = 2'd2;

    // search carry handed from cell to cell in the account chain
    typedef struct packed {
        logic                 tok;
        logic                 hit;
        logic [ACC_IDX_W-1:0] hit_idx;
        logic [HANDLE_W-1:0]  hit_conn;
        logic                 free_ok;
        logic [ACC_IDX_W-1:0] free_idx;
    } t_acct_carry;

    typedef struct packed {
        logic                  tok;
        logic                  hit;
        logic [PAIR_IDX_W-1:0] hit_idx;
        logic                  free_ok;
        logic [PAIR_IDX_W-1:0] free_idx;
        logic [PAIR_CNT_W-1:0] cnt;
    } t_pair_carry;

    typedef struct packed {
        logic                 we;
        logic [1:0]           op;
        logic [ACC_IDX_W-1:0] idx;
    } t_acct_wr;

    typedef struct packed {
        logic                  we;
        logic [1:0]            op;
        logic [PAIR_IDX_W-1:0] idx;
    } t_pair_wr;

endpackage

// ===== rtl/sag_acct_cell.sv =====
module sag_acct_cell (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sag_pkg::ACC_IDX_W-1:0] i_idx,
    input  logic [sag_pkg::ACCT_W-1:0]   i_key,
    input  logic [sag_pkg::HANDLE_W-1:0] i_conn,
    input  sag_pkg::t_acct_wr            i_wr,
    input  sag_pkg::t_acct_carry         i_carry,
    output sag_pkg::t_acct_carry         o_carry
);
    import sag_pkg::*;

    logic                r_valid;
    logic [ACCT_W-1:0]   r_key;
    logic [HANDLE_W-1:0] r_conn;
    t_acct_carry         r_carry;
    t_acct_carry         n_carry;
    logic                sel;

    assign sel = i_wr.we && (i_wr.idx == i_idx);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.tok) begin
            if (!i_carry.hit && r_valid && (r_key == i_key)) begin
                n_carry.hit      = 1'b1;
                n_carry.hit_idx  = i_idx;
                n_carry.hit_conn = r_conn;
            end
            if (!i_carry.free_ok && !r_valid) begin
                n_carry.free_ok  = 1'b1;
                n_carry.free_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
            if (sel) begin
                case (i_wr.op)
                    OP_INS:  r_valid <= 1'b1;
                    OP_CLR:  r_valid <= 1'b0;
                    default: r_valid <= r_valid;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && (i_wr.op == OP_INS)) begin
            r_key <= i_key;
        end
        if (sel && ((i_wr.op == OP_INS) || (i_wr.op == OP_CONN))) begin
            r_conn <= i_conn;
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== rtl/sag_pair_cell.sv =====
module sag_pair_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [sag_pkg::PAIR_IDX_W-1:0] i_idx,
    input  logic [sag_pkg::ADDR_W-1:0]    i_addr,
    input  logic [sag_pkg::ACCT_W-1:0]    i_acct,
    input  sag_pkg::t_pair_wr             i_wr,
    input  sag_pkg::t_pair_carry          i_carry,
    output sag_pkg::t_pair_carry          o_carry
);
    import sag_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_addr;
    logic [ACCT_W-1:0] r_acct;
    t_pair_carry       r_carry;
    t_pair_carry       n_carry;
    logic              sel;
    logic              addr_eq;

    assign sel     = i_wr.we && (i_wr.idx == i_idx);
    assign addr_eq = r_valid && (r_addr == i_addr);

    always_comb begin
        n_carry = i_carry;
        if (i_carry.tok) begin
            if (addr_eq) begin
                n_carry.cnt = i_carry.cnt + PAIR_CNT_W'(1);
            end
            if (!i_carry.hit && addr_eq && (r_acct == i_acct)) begin
                n_carry.hit     = 1'b1;
                n_carry.hit_idx = i_idx;
            end
            if (!i_carry.free_ok && !r_valid) begin
                n_carry.free_ok  = 1'b1;
                n_carry.free_idx = i_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_carry <= '0;
        end else begin
            r_carry <= n_carry;
            if (sel) begin
                case (i_wr.op)
                    OP_INS:  r_valid <= 1'b1;
                    OP_CLR:  r_valid <= 1'b0;
                    default: r_valid <= r_valid;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (sel && (i_wr.op == OP_INS)) begin
            r_addr <= i_addr;
            r_acct <= i_acct;
        end
    end

    assign o_carry = r_carry;

endmodule

// ===== rtl/session_admission_guard.sv =====
// Channel   Direction  Handshake                      Payload
// s_axis    in         i_s_tvalid / o_s_tready        tdata: item fields, tuser: kind
// m_axis    out        o_m_tvalid / i_m_tready        tdata: result fields
// cfg       in         i_cfg_valid / o_cfg_ready      register index and write data
//
// An item passes through the accept, a start, a search token walking one cell a cycle down
// each of the two cell chains, the latch of the chain summaries, and a write. The walk down
// the longer of the two cell chains dominates.
// Reset is synchronous, active low, and clears every valid bit at once.
// A stalled result holds the write cycle; no new item is taken until it completes.
module session_admission_guard (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [31:0] account_id, [32] address_present, [64:33] client_address,
    // [80:65] connection_handle, [87:81] zero
    input  logic [sag_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] kind
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [0] account_already_live, [16:1] previous_handle,
    // [17] address_cap_exceeded, [18] table_full, [23:19] zero
    output logic [sag_pkg::M_TDATA_W-1:0] o_m_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [sag_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sag_pkg::CAP_W-1:0]     i_cfg_data
);
    import sag_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SWEEP = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]          r_state;
    logic                r_start;
    logic                r_one_per;
    logic [CAP_W-1:0]    r_cap;
    logic                r_kind;
    logic [ACCT_W-1:0]   r_acct;
    logic                r_has_addr;
    logic [ADDR_W-1:0]   r_addr;
    logic [HANDLE_W-1:0] r_handle;
    logic                r_a_done;
    logic                r_p_done;
    t_acct_carry         r_a_res;
    t_pair_carry         r_p_res;
    logic                r_o_valid;
    logic [M_TDATA_W-1:0] r_o_data;

    t_acct_carry acct_chain [ACCOUNT_SLOTS+1];
    t_pair_carry pair_chain [PAIR_SLOTS+1];
    t_acct_wr    acct_wr;
    t_pair_wr    pair_wr;

    logic                s_acc;
    logic                go;
    logic                live;
    logic                full;
    logic                cap_hit;
    logic                pair_ins;
    logic [CAP_W:0]      cnt_final;

    assign o_s_tready  = (r_state == S_IDLE) && !r_start;
    assign o_cfg_ready = 1'b1;
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign go          = !r_o_valid || i_m_tready;

    // token in the top bit, empty summary below it
    assign acct_chain[0] = {r_start, {($bits(t_acct_carry)-1){1'b0}}};
    assign pair_chain[0] = {r_start, {($bits(t_pair_carry)-1){1'b0}}};

    for (genvar k = 0; k < ACCOUNT_SLOTS; k++) begin : g_acct
        sag_acct_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (ACC_IDX_W'(k)),
            .i_key   (r_acct),
            .i_conn  (r_handle),
            .i_wr    (acct_wr),
            .i_carry (acct_chain[k]),
            .o_carry (acct_chain[k+1])
        );
    end

    for (genvar k = 0; k < PAIR_SLOTS; k++) begin : g_pair
        sag_pair_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (PAIR_IDX_W'(k)),
            .i_addr  (r_addr),
            .i_acct  (r_acct),
            .i_wr    (pair_wr),
            .i_carry (pair_chain[k]),
            .o_carry (pair_chain[k+1])
        );
    end

    always_comb begin
        live = r_one_per && r_a_res.hit && (r_a_res.hit_conn != '0) &&
               (r_a_res.hit_conn != r_handle);
        pair_ins  = r_has_addr && !r_p_res.hit && r_p_res.free_ok;
        full      = (!r_a_res.hit && !r_a_res.free_ok) ||
                    (r_has_addr && !r_p_res.hit && !r_p_res.free_ok);
        cnt_final = (CAP_W+1)'(r_p_res.cnt) + (CAP_W+1)'(pair_ins);
        cap_hit   = r_has_addr && (r_cap != '0) && (cnt_final > {1'b0, r_cap});

        acct_wr = '0;
        pair_wr = '0;
        if ((r_state == S_WRITE) && go) begin
            if (r_kind == KIND_REGISTER) begin
                if (r_a_res.hit) begin
                    acct_wr = '{we: 1'b1, op: OP_CONN, idx: r_a_res.hit_idx};
                end else if (r_a_res.free_ok) begin
                    acct_wr = '{we: 1'b1, op: OP_INS, idx: r_a_res.free_idx};
                end
                if (pair_ins) begin
                    pair_wr = '{we: 1'b1, op: OP_INS, idx: r_p_res.free_idx};
                end
            end else begin
                if (r_a_res.hit && (r_a_res.hit_conn == r_handle)) begin
                    acct_wr = '{we: 1'b1, op: OP_CLR, idx: r_a_res.hit_idx};
                end
                if (r_has_addr && r_p_res.hit) begin
                    pair_wr = '{we: 1'b1, op: OP_CLR, idx: r_p_res.hit_idx};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_start   <= 1'b0;
            r_one_per <= 1'b0;
            r_cap     <= '0;
            r_a_done  <= 1'b0;
            r_p_done  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ONE_PER_ACCOUNT: r_one_per <= i_cfg_data[0];
                    CFG_MAX_PER_ADDRESS: r_cap     <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == S_WRITE) && go && (r_kind == KIND_REGISTER)) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            r_start <= s_acc;
            case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_state  <= S_SWEEP;
                        r_a_done <= 1'b0;
                        r_p_done <= 1'b0;
                    end
                end
                S_SWEEP: begin
                    // latch each chain's summary as its token falls off the end
                    if (acct_chain[ACCOUNT_SLOTS].tok) r_a_done <= 1'b1;
                    if (pair_chain[PAIR_SLOTS].tok)    r_p_done <= 1'b1;
                    if (r_a_done && r_p_done) r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (go) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_kind     <= i_s_tuser;
            r_acct     <= i_s_tdata[31:0];
            r_has_addr <= i_s_tdata[32];
            r_addr     <= i_s_tdata[64:33];
            r_handle   <= i_s_tdata[80:65];
        end
        if ((r_state == S_SWEEP) && acct_chain[ACCOUNT_SLOTS].tok) begin
            r_a_res <= acct_chain[ACCOUNT_SLOTS];
        end
        if ((r_state == S_SWEEP) && pair_chain[PAIR_SLOTS].tok) begin
            r_p_res <= pair_chain[PAIR_SLOTS];
        end
        if ((r_state == S_WRITE) && go && (r_kind == KIND_REGISTER)) begin
            r_o_data <= {5'd0, full, cap_hit,
                         (live ? r_a_res.hit_conn : {HANDLE_W{1'b0}}), live};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

`ifndef ASSERT_OFF
    a_rise_from_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_state) == S_WRITE)
        else $error("result raised outside the write cycle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_acc |=> r_start && (r_state == S_SWEEP))
        else $error("accepted item did not start a search");

    a_unreg_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) && (r_kind == KIND_UNREGISTER) && go && !r_o_valid
        |=> !o_m_tvalid)
        else $error("unregister item produced a result");
`endif

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import sag_pkg::*;

    localparam int HUSH_LIMIT = 20000;
    localparam int SETTLE_CYCLES = ACCOUNT_SLOTS + PAIR_SLOTS + 40;

    typedef struct packed {
        logic                table_full;
        logic                cap_exceeded;
        logic [HANDLE_W-1:0] previous_handle;
        logic                already_live;
    } admission_t;

    class admission_board;
        bit                one_per_acct;
        bit [CAP_W-1:0]    addr_cap;
        bit                acct_used[ACCOUNT_SLOTS];
        bit [ACCT_W-1:0]   acct_key[ACCOUNT_SLOTS];
        bit [HANDLE_W-1:0] acct_handle[ACCOUNT_SLOTS];
        bit                pair_used[PAIR_SLOTS];
        bit [ADDR_W-1:0]   pair_addr[PAIR_SLOTS];
        bit [ACCT_W-1:0]   pair_acct[PAIR_SLOTS];
        admission_t        verdicts[$];
        int                mismatches;

        function void set_reg(bit [CFG_IDX_W-1:0] idx, bit [CAP_W-1:0] val);
            if (idx == CFG_ONE_PER_ACCOUNT) one_per_acct = val[0];
            else if (idx == CFG_MAX_PER_ADDRESS) addr_cap = val;
        endfunction

        function void note(bit kind, bit [ACCT_W-1:0] acct, bit has_addr,
                           bit [ADDR_W-1:0] addr, bit [HANDLE_W-1:0] hdl);
            int a;
            int p;
            int f;
            int cnt;
            admission_t v;
            a = -1;
            p = -1;
            f = -1;
            cnt = 0;
            v = '0;
            for (int i = 0; i < ACCOUNT_SLOTS; i++)
                if (a < 0 && acct_used[i] && acct_key[i] == acct) a = i;
            if (has_addr)
                for (int i = 0; i < PAIR_SLOTS; i++)
                    if (p < 0 && pair_used[i] && pair_addr[i] == addr && pair_acct[i] == acct)
                        p = i;
            if (kind == KIND_UNREGISTER) begin
                if (a >= 0 && acct_handle[a] == hdl) acct_used[a] = 0;
                if (p >= 0) pair_used[p] = 0;
                return;
            end
            if (one_per_acct && a >= 0 && acct_handle[a] != 0 && acct_handle[a] != hdl) begin
                v.already_live = 1;
                v.previous_handle = acct_handle[a];
            end
            if (a < 0) begin
                for (int i = 0; i < ACCOUNT_SLOTS; i++)
                    if (a < 0 && !acct_used[i]) a = i;
                if (a >= 0) begin
                    acct_used[a] = 1;
                    acct_key[a] = acct;
                end
            end
            if (a >= 0) acct_handle[a] = hdl;
            else v.table_full = 1;
            if (has_addr) begin
                if (p < 0) begin
                    for (int i = 0; i < PAIR_SLOTS; i++)
                        if (f < 0 && !pair_used[i]) f = i;
                    if (f >= 0) begin
                        pair_used[f] = 1;
                        pair_addr[f] = addr;
                        pair_acct[f] = acct;
                    end else begin
                        v.table_full = 1;
                    end
                end
                for (int i = 0; i < PAIR_SLOTS; i++)
                    if (pair_used[i] && pair_addr[i] == addr) cnt++;
                if (addr_cap != 0 && cnt > addr_cap) v.cap_exceeded = 1;
            end
            verdicts.push_back(v);
        endfunction

        function void check(logic [M_TDATA_W-1:0] data);
            admission_t want;
            admission_t got;
            got = data[$bits(admission_t)-1:0];
            if (verdicts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", data);
                return;
            end
            want = verdicts.pop_front();
            if (got !== want || data[M_TDATA_W-1:$bits(admission_t)] !== '0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: live %b/%b prev %h/%h cap %b/%b full %b/%b pad %h",
                             want.already_live, got.already_live, want.previous_handle,
                             got.previous_handle, want.cap_exceeded, got.cap_exceeded,
                             want.table_full, got.table_full,
                             data[M_TDATA_W-1:$bits(admission_t)]);
            end
        endfunction
    endclass

    logic                 i_clk = 0;
    logic                 i_rst_n = 0;
    logic                 i_s_tvalid = 0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 i_s_tuser = 0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 i_cfg_valid = 0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CAP_W-1:0]     i_cfg_data = '0;

    admission_board board = new();
    int  tx_idle_pct = 0;
    int  rx_stall_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  hush = 0;

    session_admission_guard dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // receiver side, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0) begin
            hold_req <= 0;
            hold_left <= 4000;
            i_m_tready <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_s_tvalid && o_s_tready)
            board.note(i_s_tuser, i_s_tdata[31:0], i_s_tdata[32], i_s_tdata[64:33],
                       i_s_tdata[80:65]);
        if (i_rst_n && o_m_tvalid && i_m_tready) board.check(o_m_tdata);
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready))
            hush <= 0;
        else
            hush <= hush + 1;
        if (hush >= HUSH_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic write_reg(bit [CFG_IDX_W-1:0] idx, bit [CAP_W-1:0] val);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, val);
        i_cfg_valid <= 0;
    endtask

    task automatic send_item(bit kind, bit [31:0] acct, bit has_addr, bit [31:0] addr,
                             bit [15:0] hdl);
        i_s_tvalid <= 1;
        i_s_tuser <= kind;
        i_s_tdata <= {7'b0, hdl, addr, has_addr, acct};
        do @(posedge i_clk); while (!o_s_tready);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
    endtask

    // drain all results, then let a trailing unregister finish its walk
    task automatic settle();
        @(posedge i_clk);
        i_s_tvalid <= 0;
        while (board.verdicts.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_random();
        bit [31:0] acct_pool[8] = '{0, 1, 2, 3, 32'hFFFF_FFFF, 32'h8000_0000, 77, 78};
        bit [31:0] addr_pool[3] = '{0, 32'hC0A8_0001, 32'hFFFF_FFFF};
        bit [31:0] acct;
        bit [31:0] addr;
        bit [15:0] hdl;
        acct = ($urandom_range(99) < 85) ? acct_pool[$urandom_range(7)] : $urandom;
        addr = ($urandom_range(99) < 85) ? addr_pool[$urandom_range(2)] : $urandom;
        hdl = ($urandom_range(99) < 70) ? 16'($urandom_range(3)) : 16'($urandom);
        send_item($urandom_range(99) < 40, acct, $urandom_range(99) < 80, addr, hdl);
    endtask

    initial begin
        bit [CAP_W-1:0] caps[6] = '{0, 1, 2, 16'hFFFF, 3, 1};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset config: no live report, no cap
        send_item(KIND_REGISTER, 5, 1, 9, 3);
        send_item(KIND_REGISTER, 5, 1, 9, 4);
        send_item(KIND_REGISTER, 6, 1, 9, 1);
        settle();
        write_reg(CFG_ONE_PER_ACCOUNT, 1);
        write_reg(CFG_MAX_PER_ADDRESS, 1);
        write_reg(4'hF, 16'hFFFF);
        write_reg(4'h2, 0);
        send_item(KIND_REGISTER, 0, 1, 0, 0);
        send_item(KIND_REGISTER, 0, 1, 0, 5);
        send_item(KIND_REGISTER, 0, 1, 0, 5);
        send_item(KIND_REGISTER, 0, 1, 0, 7);
        send_item(KIND_REGISTER, 32'hFFFF_FFFF, 1, 0, 16'hFFFF);
        send_item(KIND_REGISTER, 12, 0, 32'hFFFF_FFFF, 9);
        send_item(KIND_UNREGISTER, 0, 1, 0, 9);
        send_item(KIND_REGISTER, 0, 0, 0, 8);
        send_item(KIND_UNREGISTER, 0, 1, 0, 8);
        send_item(KIND_UNREGISTER, 999, 1, 5, 1);
        send_item(KIND_UNREGISTER, 32'hFFFF_FFFF, 1, 0, 16'hFFFF);
        send_item(KIND_REGISTER, 0, 1, 32'hFFFF_FFFF, 1);
        send_item(KIND_REGISTER, 32'hAAAA_5555, 1, 32'h5555_AAAA, 16'hAAAA);
        send_item(KIND_REGISTER, 32'h5555_AAAA, 1, 32'h5555_AAAA, 16'h5555);
        send_item(KIND_UNREGISTER, 5, 0, 9, 4);
        settle();

        // fill both tables past their depth, then unregister the filling entries again
        write_reg(CFG_MAX_PER_ADDRESS, 16'hFFFF);
        for (int i = 0; i < 280; i++)
            send_item(KIND_REGISTER, 1000 + i, 1, i % 2, 16'(i + 1));
        send_item(KIND_REGISTER, 0, 1, 0, 5);
        for (int i = 0; i < 280; i++)
            send_item(KIND_UNREGISTER, 1000 + i, 1, i % 2, 16'(i + 1));

        for (int ph = 0; ph < 6; ph++) begin
            settle();
            write_reg(CFG_ONE_PER_ACCOUNT, ph % 3 != 0);
            write_reg(CFG_MAX_PER_ADDRESS, caps[ph]);
            tx_idle_pct = (ph % 4 == 1) ? 78 : (ph % 4 == 3) ? 26 : 0;
            rx_stall_pct = (ph % 4 == 2) ? 78 : (ph % 4 == 3) ? 26 : 0;
            if (ph == 2) hold_req = 1;
            for (int n = 0; n < 180; n++) send_random();
        end

        settle();
        if (board.mismatches == 0 && board.verdicts.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
